>>> hw/rtl/cmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmg_pkg
// shared types, codes and constants of the character map glyph lookup
// ----------------------------------------------------------------------------
package cmg_pkg;

  localparam int unsigned MaxSegmentsDef = 256;
  localparam int unsigned GlyphWordsDef  = 4096;
  localparam int unsigned IndexW         = 12;
  localparam int unsigned CountW         = 13;
  localparam int unsigned CfgIdxW        = 4;
  localparam int unsigned CfgDataW       = 16;

  typedef enum logic [1:0] {
    CMD_WR_SEG  = 2'd0,
    CMD_WR_WORD = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FMT_BYTE = 2'd0,
    FMT_SEG  = 2'd1,
    FMT_GRP  = 2'd2,
    FMT_BAD  = 2'd3
  } fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TABLE_FORMAT  = 4'd0,
    REG_SEGMENT_COUNT = 4'd1
  } reg_e;

  typedef struct packed {
    logic [31:0] start_code;
    logic [31:0] end_code;
    logic [31:0] base;
    logic [15:0] offset;
  } seg_entry_t;

  typedef struct packed {
    logic              en;
    logic [IndexW-1:0] index;
    seg_entry_t        entry;
  } seg_wr_t;

  // lookup token that walks the cell row
  typedef struct packed {
    logic              valid;
    fmt_e              fmt;
    logic [31:0]       code;
    logic              done;
    logic              miss;
    logic [IndexW-1:0] hit;
    logic [15:0]       sc;
    logic [15:0]       delta;
    logic [15:0]       ro;
  } token_t;

endpackage

>>> hw/rtl/cmg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmg channel interfaces
// command, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface cmg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] entry_index;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic [31:0] glyph_base;
  logic [15:0] range_offset;
  logic [15:0] glyph_word;
  logic [31:0] code_point;
  modport source (output valid, command, entry_index, range_start, range_end,
                  glyph_base, range_offset, glyph_word, code_point, input ready);
  modport sink (input valid, command, entry_index, range_start, range_end,
                glyph_base, range_offset, glyph_word, code_point, output ready);
endinterface

interface cmg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] glyph_id;
  modport source (output valid, glyph_id, input ready);
  modport sink (input valid, glyph_id, output ready);
endinterface

interface cmg_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/cmg_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmg_cell
// one segment entry and the token stage that checks the code against it
// ----------------------------------------------------------------------------
module cmg_cell import cmg_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  seg_wr_t           wr_i,
  input  logic [CountW-1:0] scan_n_i,
  input  token_t            tok_i,
  output token_t            tok_o
);

  localparam logic [CountW-1:0] CellNum = CountW'(CellIdx);
  localparam logic [IndexW-1:0] CellIx  = IndexW'(CellIdx);

  seg_entry_t entry_q;
  token_t     tok_d, tok_q;
  logic       active;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.index == CellIx) begin
      entry_q <= wr_i.entry;
    end
  end

  assign active = (CellNum < scan_n_i);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.done && active) begin
      case (tok_i.fmt)
        FMT_SEG: begin
          if (entry_q.end_code[15:0] == 16'hFFFF) begin
            tok_d.done = 1'b1;
            tok_d.miss = 1'b1;
          end else if (entry_q.end_code[15:0] >= tok_i.code[15:0]) begin
            tok_d.done  = 1'b1;
            tok_d.hit   = CellIx;
            tok_d.sc    = entry_q.start_code[15:0];
            tok_d.delta = entry_q.base[15:0];
            tok_d.ro    = entry_q.offset;
          end
        end
        FMT_GRP: begin
          if (tok_i.code >= entry_q.start_code && tok_i.code <= entry_q.end_code) begin
            // fold base minus start so the exit adds the code
            tok_d.done  = 1'b1;
            tok_d.delta = entry_q.base[15:0] - entry_q.start_code[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> hw/rtl/cmg_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmg_row
// row of segment cells, the token moves one cell per cycle
// ----------------------------------------------------------------------------
module cmg_row import cmg_pkg::*; #(
  parameter int unsigned MaxSegments = MaxSegmentsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  seg_wr_t                wr_i,
  input  logic [CountW-1:0]      scan_n_i,
  input  token_t                 tok_i,
  output token_t                 tok_o,
  output logic [MaxSegments-1:0] busy_o
);

  token_t tok [MaxSegments+1];

  assign tok[0] = tok_i;

  for (genvar i = 0; i < MaxSegments; i++) begin : g_cell
    cmg_cell #(.CellIdx(i)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_i     (wr_i),
      .scan_n_i (scan_n_i),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
    assign busy_o[i] = tok[i+1].valid;
  end

  assign tok_o = tok[MaxSegments];

endmodule

>>> hw/rtl/char_map_glyph_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_map_glyph_lookup
// character code to glyph id translation for byte, segment and group maps
// ----------------------------------------------------------------------------
// in_i carries one command word: a segment write, a glyph word write or a
// lookup. Writes give no result. A lookup sends a token down a row of
// MaxSegments cells, one cell per cycle, each cell holding one segment or
// group entry; the first matching cell latches its entry into the token.
// A glyph memory read follows the row where the format needs one, then the
// read state loads the out_o register; the next word is taken once the
// result is in the output register. One lookup is in flight at a time and
// the row length sets the lookup time. cfg_i writes table_format (index 0)
// and segment_count (index 1) and is always ready; the user must write it
// only while no lookup is in flight, which the block does not enforce.
// Reset sets table_format to the segment format and segment_count to 0 and
// empties the row; the segment and glyph stores keep no reset value.
// While out_o is stalled the finished result waits in the final state and
// no new word is accepted.
// ----------------------------------------------------------------------------
module char_map_glyph_lookup import cmg_pkg::*; #(
  parameter int unsigned MaxSegments = MaxSegmentsDef,
  parameter int unsigned GlyphWords  = GlyphWordsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cmg_in_if.sink   in_i,
  cmg_out_if.source out_o,
  cmg_cfg_if.sink  cfg_i
);

  localparam int unsigned GwAw = $clog2(GlyphWords);
  localparam logic [16:0] GwLimit = 17'(GlyphWords);
  localparam logic [CountW-1:0] SegMax = CountW'(MaxSegments);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;

  logic [1:0] state_q, state_d;
  fmt_e       fmt_q;
  logic [8:0] seg_cnt_q;
  logic [CountW-1:0] scan_n;

  logic [15:0] glyph_mem [GlyphWords];
  logic [15:0] rdata_q;
  logic        mem_we, mem_re;
  logic [GwAw-1:0] wr_addr, rd_addr;

  logic     accept;
  seg_wr_t  seg_wr;
  token_t   tok_in, tok_out;
  logic [MaxSegments-1:0] busy;

  logic        need_mem_d, need_mem_q;
  logic [15:0] imm_d, imm_q;
  logic [15:0] delta_q;
  fmt_e        lk_fmt_q;
  logic [15:0] idx, code16, fin;
  logic        out_valid_q;
  logic [15:0] out_glyph_q;
  logic        out_free;

  // configuration
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_SEG;
      seg_cnt_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_TABLE_FORMAT:  fmt_q     <= fmt_e'(cfg_i.data[1:0]);
        REG_SEGMENT_COUNT: seg_cnt_q <= cfg_i.data[8:0];
        default: ;
      endcase
    end
  end

  assign scan_n = (CountW'(seg_cnt_q) > SegMax) ? SegMax : CountW'(seg_cnt_q);

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign seg_wr.en               = accept && in_i.command == CMD_WR_SEG;
  assign seg_wr.index            = in_i.entry_index;
  assign seg_wr.entry.start_code = in_i.range_start;
  assign seg_wr.entry.end_code   = in_i.range_end;
  assign seg_wr.entry.base       = in_i.glyph_base;
  assign seg_wr.entry.offset     = in_i.range_offset;

  always_comb begin
    tok_in       = '0;
    tok_in.valid = accept && in_i.command == CMD_LOOKUP;
    tok_in.fmt   = fmt_q;
    tok_in.code  = in_i.code_point;
  end

  cmg_row #(.MaxSegments(MaxSegments)) u_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (seg_wr),
    .scan_n_i (scan_n),
    .tok_i    (tok_in),
    .tok_o    (tok_out),
    .busy_o   (busy)
  );

  // exit of the row: immediate answer or glyph memory address
  assign code16 = tok_out.code[15:0];
  assign idx = (tok_out.ro >> 1) + (code16 - tok_out.sc) + 16'(tok_out.hit) - 16'(scan_n);

  always_comb begin
    need_mem_d = 1'b0;
    imm_d      = '0;
    rd_addr    = '0;
    case (tok_out.fmt)
      FMT_BYTE: begin
        if (tok_out.code <= 32'd255) begin
          need_mem_d = 1'b1;
          rd_addr    = GwAw'(tok_out.code[7:0]);
        end
      end
      FMT_SEG: begin
        if (tok_out.code < 32'h0000_FFFF && tok_out.done && !tok_out.miss &&
            tok_out.sc <= code16) begin
          if (tok_out.ro == 16'd0) begin
            imm_d = tok_out.delta + code16;
          end else if ({1'b0, idx} < GwLimit) begin
            need_mem_d = 1'b1;
            rd_addr    = idx[GwAw-1:0];
          end
        end
      end
      FMT_GRP: begin
        if (tok_out.done) imm_d = tok_out.delta + code16;
      end
      default: imm_d = 16'hFFFF;
    endcase
  end

  assign mem_re  = (state_q == ST_SCAN) && tok_out.valid && need_mem_d;
  assign mem_we  = accept && in_i.command == CMD_WR_WORD &&
                   {5'd0, in_i.entry_index} < GwLimit;
  assign wr_addr = GwAw'({5'd0, in_i.entry_index});

  always_ff @(posedge clk_i) begin
    if (mem_we) glyph_mem[wr_addr] <= in_i.glyph_word;
    if (mem_re) rdata_q <= glyph_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && tok_out.valid) begin
      need_mem_q <= need_mem_d;
      imm_q      <= imm_d;
      delta_q    <= tok_out.delta;
      lk_fmt_q   <= tok_out.fmt;
    end
  end

  always_comb begin
    fin = imm_q;
    if (need_mem_q) begin
      if (lk_fmt_q == FMT_BYTE) fin = {8'd0, rdata_q[7:0]};
      else if (rdata_q == 16'd0) fin = '0;
      else fin = delta_q + rdata_q;
    end
  end

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (tok_in.valid) state_d = ST_SCAN;
      ST_SCAN: if (tok_out.valid) state_d = ST_RD;
      ST_RD:   if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RD && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD && out_free) out_glyph_q <= fin;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.glyph_id = out_glyph_q;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(busy))
    else $error("more than one lookup token in the cell row");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> busy == '0)
    else $error("token in the row while idle");
  a_exit_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && tok_out.valid) |=> state_q == ST_RD)
    else $error("row exit did not move to the read state");
`endif

endmodule
